// File: rtl/uart_tx_rx_ring_buffers_defines.svh
// Assertion macros shared by the ring buffer RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef UART_TX_RX_RING_BUFFERS_DEFINES_SVH
`define UART_TX_RX_RING_BUFFERS_DEFINES_SVH

// check a property on every rising edge outside reset
`define UARTRB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition never holds on a rising edge outside reset
`define UARTRB_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: rtl/uartrb_pkg.sv
// Package for the UART ring buffers: beat types, operation codes, FSM states.
// Used by every module of the block; no dependencies.
package uartrb_pkg;

	// default ring depth in bytes
	localparam int unsigned DEPTH_DEF = 64 * 64;

	// operation codes carried in the kind field
	localparam logic [2:0] KIND_RESERVE = 3'd0;
	localparam logic [2:0] KIND_TX_DATA = 3'd1;
	localparam logic [2:0] KIND_LINE_RDY = 3'd2;
	localparam logic [2:0] KIND_RX_BYTE = 3'd3;
	localparam logic [2:0] KIND_SW_READ = 3'd4;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_byte;
		logic [7:0] burst_length;
	} in_item_t;

	typedef struct packed {
		logic       reserve_ok;
		logic       line_valid;
		logic [7:0] line_byte;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       rx_available;
		logic       tx_irq_enable;
		logic       rx_irq_enable;
		logic       rx_dropped;
	} out_item_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} ctrl_state_t;

endpackage

// File: rtl/uartrb_ctrl.sv
// Controller FSM for the UART ring buffers: accepts beats, sequences execute and response.
// Depends on uartrb_pkg and uart_tx_rx_ring_buffers_defines.svh.
`include "uart_tx_rx_ring_buffers_defines.svh"

module uartrb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	output uartrb_pkg::ctrl_cmd_t cmd
);
	import uartrb_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// advance through execute and response; a new beat may enter during response
	always_comb begin
		state_d  = state_q;
		busy     = 1'b0;
		done     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				done     = 1'b1;
				cmd.load = start;
				state_d  = start ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`UARTRB_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted beat did not enter execute")
	`UARTRB_ASSERT(a_exec_done, cmd.exec |=> done, "execute not followed by result strobe")
	`UARTRB_ASSERT(a_done_single, done |=> !done, "result strobe held longer than one cycle")

endmodule

// File: rtl/uartrb_dp.sv
// Datapath for the UART ring buffers: transmit and receive rings, pointers, flags.
// Depends on uartrb_pkg; driven by commands from uartrb_ctrl.
module uartrb_dp #(
	parameter int unsigned DEPTH = uartrb_pkg::DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  uartrb_pkg::ctrl_cmd_t cmd,
	input  uartrb_pkg::in_item_t  item,
	output uartrb_pkg::out_item_t result
);
	import uartrb_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = ((PW > 8) ? PW : 8) + 1;
	localparam logic [CW-1:0] DEPTH_W = CW'(DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	// wrap a ring pointer
	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	in_item_t item_q;

	logic [7:0] tx_mem [DEPTH];
	logic [7:0] rx_mem [DEPTH];
	logic [7:0] tx_rdata_q;
	logic [7:0] rx_rdata_q;

	logic [PW-1:0] tx_rd_q;
	logic [PW-1:0] tx_wr_q;
	logic [PW-1:0] rx_rd_q;
	logic [PW-1:0] rx_wr_q;
	logic [7:0]    burst_q;
	logic          tx_en_q;
	logic          rx_en_q;

	logic reserve_ok_q;
	logic line_valid_q;
	logic read_valid_q;
	logic rx_dropped_q;

	logic [CW-1:0] free_space;
	logic          burst_open;
	logic          tx_empty;
	logic          rx_empty;
	logic          rx_full;
	logic          do_reserve;
	logic          do_tx_write;
	logic          do_line_pop;
	logic          do_tx_off;
	logic          do_rx_write;
	logic          do_rx_drop;
	logic          do_rx_full;
	logic          do_sw_pop;

	// capture the beat on accept
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	// decode the operation against the ring state
	always_comb begin
		if (tx_rd_q > tx_wr_q) begin
			free_space = CW'(tx_rd_q) - CW'(tx_wr_q) - CW'(1);
		end else begin
			free_space = CW'(tx_rd_q) + DEPTH_W - CW'(tx_wr_q) - CW'(1);
		end
		burst_open  = (burst_q != 8'd0);
		tx_empty    = (tx_rd_q == tx_wr_q);
		rx_empty    = (rx_rd_q == rx_wr_q);
		rx_full     = (ptr_next(rx_wr_q) == rx_rd_q);
		do_reserve  = 1'b0;
		do_tx_write = 1'b0;
		do_line_pop = 1'b0;
		do_tx_off   = 1'b0;
		do_rx_write = 1'b0;
		do_rx_drop  = 1'b0;
		do_rx_full  = 1'b0;
		do_sw_pop   = 1'b0;
		case (item_q.kind)
			KIND_RESERVE: begin
				do_reserve = !burst_open && (free_space > CW'(item_q.burst_length));
			end
			KIND_TX_DATA: begin
				do_tx_write = burst_open;
			end
			KIND_LINE_RDY: begin
				do_line_pop = tx_en_q && !tx_empty;
				do_tx_off   = tx_en_q && tx_empty;
			end
			KIND_RX_BYTE: begin
				do_rx_drop  = !rx_en_q || rx_full;
				do_rx_full  = rx_en_q && rx_full;
				do_rx_write = rx_en_q && !rx_full;
			end
			KIND_SW_READ: begin
				do_sw_pop = !rx_empty;
			end
			default: begin
			end
		endcase
	end

	// update pointers, burst count and enables on execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_rd_q      <= '0;
			tx_wr_q      <= '0;
			rx_rd_q      <= '0;
			rx_wr_q      <= '0;
			burst_q      <= 8'd0;
			tx_en_q      <= 1'b1;
			rx_en_q      <= 1'b1;
			reserve_ok_q <= 1'b0;
			line_valid_q <= 1'b0;
			read_valid_q <= 1'b0;
			rx_dropped_q <= 1'b0;
		end else if (cmd.exec) begin
			reserve_ok_q <= do_reserve;
			line_valid_q <= do_line_pop;
			read_valid_q <= do_sw_pop;
			rx_dropped_q <= do_rx_drop;
			if (item_q.kind == KIND_RESERVE) begin
				tx_en_q <= 1'b1;
			end
			if (do_tx_off) begin
				tx_en_q <= 1'b0;
			end
			if (do_reserve) begin
				burst_q <= item_q.burst_length;
			end
			if (do_tx_write) begin
				tx_wr_q <= ptr_next(tx_wr_q);
				burst_q <= burst_q - 8'd1;
			end
			if (do_line_pop) begin
				tx_rd_q <= ptr_next(tx_rd_q);
			end
			if (do_rx_write) begin
				rx_wr_q <= ptr_next(rx_wr_q);
			end
			if (do_rx_full) begin
				rx_en_q <= 1'b0;
			end
			if (do_sw_pop) begin
				rx_rd_q <= ptr_next(rx_rd_q);
				rx_en_q <= 1'b1;
			end
		end
	end

	// transmit ring: write burst bytes, read the head for the line
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (do_tx_write) begin
				tx_mem[tx_wr_q] <= item_q.data_byte;
			end
			tx_rdata_q <= tx_mem[tx_rd_q];
		end
	end

	// receive ring: store line bytes, read the head for software
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (do_rx_write) begin
				rx_mem[rx_wr_q] <= item_q.data_byte;
			end
			rx_rdata_q <= rx_mem[rx_rd_q];
		end
	end

	// assemble the result beat
	always_comb begin
		result.reserve_ok    = reserve_ok_q;
		result.line_valid    = line_valid_q;
		result.line_byte     = line_valid_q ? tx_rdata_q : 8'd0;
		result.read_valid    = read_valid_q;
		result.read_byte     = read_valid_q ? rx_rdata_q : 8'd0;
		result.rx_available  = (rx_rd_q != rx_wr_q);
		result.tx_irq_enable = tx_en_q;
		result.rx_irq_enable = rx_en_q;
		result.rx_dropped    = rx_dropped_q;
	end

endmodule

// File: rtl/uart_tx_rx_ring_buffers.sv
// Top level of the UART transmit and receive ring buffers.
// Depends on uartrb_pkg, uartrb_ctrl, uartrb_dp and the assertion macro header.
//
//  channel   handshake          payload               direction
//  item      start / busy       uartrb_pkg::in_item_t in
//  result    done (strobe)      uartrb_pkg::out_item_t out
//
// Each beat passes an execute state, to update pointers and read the ring memory head,
// then a response state with the result on the ports and done high. The registered read
// port of the rings calls for this; a new beat can be taken in the response state.
// Reset zeroes pointers and burst count and sets both enables; ring contents are kept.
// The receiver cannot stall: done marks a result for one cycle only.
`include "uart_tx_rx_ring_buffers_defines.svh"

module uart_tx_rx_ring_buffers #(
	parameter int unsigned DEPTH = uartrb_pkg::DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  uartrb_pkg::in_item_t  item,
	output logic                  done,
	output uartrb_pkg::out_item_t result
);
	import uartrb_pkg::*;

	ctrl_cmd_t cmd;

	uartrb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	uartrb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

	`UARTRB_ASSERT(a_drop_disables, done && result.rx_dropped |-> !result.rx_irq_enable, "receive left enabled after a drop")
	`UARTRB_ASSERT(a_line_enabled, done && result.line_valid |-> result.tx_irq_enable, "line byte sent while transmit disabled")
	`UARTRB_ASSERT(a_read_enables, done && result.read_valid |-> result.rx_irq_enable, "receive not re-enabled after a read")

endmodule

// File: tb/uartrb_checker.sv
// Checker for the UART ring buffers: predicts every result beat and compares it.
// Watches the start/busy and done channels of the block; depends on uartrb_pkg.
module uartrb_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  uartrb_pkg::in_item_t  item,
	input  logic                  done,
	input  uartrb_pkg::out_item_t result,
	output int                    outstanding,
	output int                    fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import uartrb_pkg::*;

	localparam int unsigned RING = DEPTH_DEF;

	// shadow copy of both rings and their control state
	logic [7:0]  tx_mem [RING];
	logic [7:0]  rx_mem [RING];
	int unsigned tx_rd, tx_wr, rx_rd, rx_wr;
	int unsigned burst_left;
	logic        tx_en, rx_en;

	out_item_t   ring_results_q[$];
	out_item_t   want;
	int          mismatches = 0;
	int          results_seen = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		mismatches++;
		$display("%0t ns: result %0d %s: got %0h, expected %0h",
			$time, results_seen, what, got_v, want_v);
	endtask

	task automatic check_field(input string what, input int got_v, input int want_v);
		if (got_v != want_v) begin
			report_mismatch(what, got_v, want_v);
		end
	endtask

	// advance the shadow rings by one accepted beat and return its result
	function automatic out_item_t step_rings(input in_item_t it);
		out_item_t   r;
		int unsigned room;
		r = '0;
		case (it.kind)
			KIND_RESERVE: begin
				room = (tx_rd + RING - tx_wr - 1) % RING;
				if (burst_left == 0 && room > it.burst_length) begin
					burst_left = 32'(it.burst_length);
					r.reserve_ok = 1'b1;
				end
				tx_en = 1'b1;
			end
			KIND_TX_DATA: begin
				if (burst_left != 0) begin
					tx_mem[tx_wr] = it.data_byte;
					tx_wr = (tx_wr + 1) % RING;
					burst_left--;
				end
			end
			KIND_LINE_RDY: begin
				// masked while the transmit event is disabled
				if (tx_en) begin
					if (tx_rd != tx_wr) begin
						r.line_byte = tx_mem[tx_rd];
						r.line_valid = 1'b1;
						tx_rd = (tx_rd + 1) % RING;
					end else begin
						tx_en = 1'b0;
					end
				end
			end
			KIND_RX_BYTE: begin
				if (!rx_en) begin
					r.rx_dropped = 1'b1;
				end else if ((rx_wr + 1) % RING == rx_rd) begin
					r.rx_dropped = 1'b1;
					rx_en = 1'b0;
				end else begin
					rx_mem[rx_wr] = it.data_byte;
					rx_wr = (rx_wr + 1) % RING;
				end
			end
			KIND_SW_READ: begin
				if (rx_rd != rx_wr) begin
					r.read_byte = rx_mem[rx_rd];
					r.read_valid = 1'b1;
					rx_rd = (rx_rd + 1) % RING;
					rx_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.rx_available = (rx_rd != rx_wr);
		r.tx_irq_enable = tx_en;
		r.rx_irq_enable = rx_en;
		return r;
	endfunction

	// compare the result beat first, then record the beat taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_rd = 0;
			tx_wr = 0;
			rx_rd = 0;
			rx_wr = 0;
			burst_left = 0;
			tx_en = 1'b1;
			rx_en = 1'b1;
			ring_results_q.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				results_seen++;
				if (ring_results_q.size() == 0) begin
					report_mismatch("arrived with no beat pending", int'(result), 0);
				end else begin
					want = ring_results_q.pop_front();
					check_field("reserve_ok", int'(result.reserve_ok),
						int'(want.reserve_ok));
					check_field("line_valid", int'(result.line_valid),
						int'(want.line_valid));
					check_field("line_byte", int'(result.line_byte),
						int'(want.line_byte));
					check_field("read_valid", int'(result.read_valid),
						int'(want.read_valid));
					check_field("read_byte", int'(result.read_byte),
						int'(want.read_byte));
					check_field("rx_available", int'(result.rx_available),
						int'(want.rx_available));
					check_field("tx_irq_enable", int'(result.tx_irq_enable),
						int'(want.tx_irq_enable));
					check_field("rx_irq_enable", int'(result.rx_irq_enable),
						int'(want.rx_irq_enable));
					check_field("rx_dropped", int'(result.rx_dropped),
						int'(want.rx_dropped));
				end
			end
			if (start && !busy) begin
				ring_results_q.push_back(step_rings(item));
			end
			outstanding <= ring_results_q.size();
		end
	end

endmodule

// File: tb/tb_uart_tx_rx_ring_buffers.sv
// Testbench top for the UART ring buffers: clock, reset, stimulus and verdict.
// Depends on uartrb_pkg, the block uart_tx_rx_ring_buffers and uartrb_checker.
module tb_uart_tx_rx_ring_buffers;
	timeunit 1ns;
	timeprecision 1ps;

	import uartrb_pkg::*;

	localparam int LIMIT = 50000;
	localparam int PHASE_BEATS = 260;
	localparam int SETTLE = 10;

	// kind codes the block treats as no-ops
	localparam logic [2:0] KIND_SPARE_A = 3'd5;
	localparam logic [2:0] KIND_SPARE_B = 3'd6;
	localparam logic [2:0] KIND_SPARE_C = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      done;
	out_item_t result;
	int        outstanding;
	int        fail_count;
	int        idle_pct = 0;
	int        cycle_count = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	uart_tx_rx_ring_buffers u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	uartrb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	function automatic in_item_t beat(input logic [2:0] k, input int d, input int l);
		in_item_t it;
		it.kind = k;
		it.data_byte = d[7:0];
		it.burst_length = l[7:0];
		return it;
	endfunction

	// offer one beat, with an optional idle gap ahead of it, and hold until taken
	task automatic send_beat(input in_item_t it);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// hold the sender off until every predicted result beat has come
	task automatic drain_pending();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic send_repeat(input logic [2:0] k, input int n);
		for (int i = 0; i < n; i++) begin
			send_beat(beat(k, $urandom_range(0, 255), $urandom_range(0, 255)));
		end
	endtask

	// random traffic: mostly complete bursts and balanced line traffic, some noise
	task automatic random_phase(input int budget);
		int sent;
		int pick;
		int len;
		int n;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
				send_beat(beat(KIND_RESERVE, $urandom_range(0, 255), len));
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 4) == 0) begin
						send_repeat(KIND_LINE_RDY, 1);
						sent++;
					end
					send_repeat(KIND_TX_DATA, 1);
				end
				sent += len + 1;
			end else if (pick < 88) begin
				n = $urandom_range(1, 4);
				if (pick < 50) begin
					send_repeat(KIND_LINE_RDY, n);
				end else if (pick < 70) begin
					send_repeat(KIND_RX_BYTE, n);
				end else begin
					send_repeat(KIND_SW_READ, n);
				end
				sent += n;
			end else if (pick < 95) begin
				// stray data beat, usually outside any burst
				send_repeat(KIND_TX_DATA, 1);
				sent++;
			end else begin
				send_beat(beat(3'($urandom_range(0, 7)), $urandom_range(0, 255),
					$urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	// end the run if the block stops answering
	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty rings, masked events, open burst, field extremes
		send_beat(beat(KIND_SW_READ, 8'hFF, 8'hFF));
		send_beat(beat(KIND_LINE_RDY, 8'h00, 8'h00));
		send_beat(beat(KIND_LINE_RDY, 8'hFF, 8'hFF));
		send_beat(beat(KIND_TX_DATA, 8'h5A, 8'h00));
		send_beat(beat(KIND_RESERVE, 8'h00, 3));
		send_beat(beat(KIND_RESERVE, 8'hFF, 0));
		send_beat(beat(KIND_TX_DATA, 8'h00, 8'hFF));
		send_beat(beat(KIND_TX_DATA, 8'hFF, 8'h00));
		send_beat(beat(KIND_TX_DATA, 8'hA5, 8'h5A));
		send_beat(beat(KIND_TX_DATA, 8'h3C, 8'h00));
		send_beat(beat(KIND_LINE_RDY, 8'h00, 8'h00));
		send_beat(beat(KIND_LINE_RDY, 8'h00, 8'h00));
		send_beat(beat(KIND_LINE_RDY, 8'h00, 8'h00));
		send_beat(beat(KIND_RX_BYTE, 8'hFF, 8'h00));
		send_beat(beat(KIND_RX_BYTE, 8'h00, 8'hFF));
		send_beat(beat(KIND_SW_READ, 8'h00, 8'h00));
		send_beat(beat(KIND_SW_READ, 8'h00, 8'h00));
		send_beat(beat(KIND_SW_READ, 8'h00, 8'h00));
		send_beat(beat(KIND_SPARE_A, 8'hFF, 8'hFF));
		send_beat(beat(KIND_SPARE_B, 8'h00, 8'h00));
		send_beat(beat(KIND_SPARE_C, 8'hFF, 8'hFF));
		send_beat(beat(KIND_RESERVE, 8'h00, 0));
		drain_pending();

		// random traffic under three sender idle patterns
		idle_pct = 0;
		random_phase(PHASE_BEATS);
		drain_pending();
		idle_pct = 51;
		random_phase(PHASE_BEATS);
		drain_pending();
		idle_pct = 18;
		random_phase(PHASE_BEATS);

		drain_pending();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
